FILE: hw/rtl/crt_pkg.sv
package crt_pkg;

  // fixed field widths of the beats
  localparam int GenW    = 32;
  localparam int TotalW  = 32;
  localparam int HalfW   = 16;
  localparam int OffsetW = 18;
  localparam int WlenW   = 11;
  localparam int InDataW  = 128;
  localparam int OutDataW = 40;

  // result codes
  typedef enum logic [2:0] {
    StFailed   = 3'd0,
    StStale    = 3'd1,
    StHeader   = 3'd2,
    StGeometry = 3'd3,
    StIndex    = 3'd4,
    StLength   = 3'd5,
    StStored   = 3'd6
  } status_e;

  // chunk header, last field in the lowest bits
  typedef struct packed {
    logic [HalfW-1:0]  name_len;
    logic [HalfW-1:0]  payload_len;
    logic [HalfW-1:0]  chunk_no;
    logic [HalfW-1:0]  n_chunks;
    logic [TotalW-1:0] xfer_size;
    logic [GenW-1:0]   generation;
  } hdr_t;

  // result, last field in the lowest bits
  typedef struct packed {
    logic               ready_res;
    logic [WlenW-1:0]   write_len;
    logic [OffsetW-1:0] write_offset;
    logic               adopted;
    status_e            status;
  } res_t;

  localparam int ResW = $bits(res_t);

endpackage

FILE: hw/rtl/crt_stage.sv
// one register slice of a valid/ready stream
module crt_stage #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  // take a new beat whenever the slot is empty or being drained
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: hw/rtl/crt_core.sv
// header check, geometry check and chunk bitmap for one chunk per cycle while fire_i is high
module crt_core #(
  parameter int CHUNK_SIZE  = 1024,
  parameter int MAX_CHUNKS  = 256,
  parameter int MAX_BYTES   = 262144,
  parameter int NAME_MAX    = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  crt_pkg::hdr_t hdr_i,
  output crt_pkg::res_t res_o
);

  localparam int TotW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CntW = $clog2(MAX_CHUNKS + 1);
  localparam int IdxW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam logic [31:0] NameMaxC  = 32'(NAME_MAX);
  localparam logic [31:0] MaxBytesC = 32'(MAX_BYTES);
  localparam logic [16:0] MaxChC    = 17'(MAX_CHUNKS);
  localparam logic [15:0] ChunkC    = 16'(CHUNK_SIZE);

  logic [31:0]           cur_gen_q, rej_gen_q;
  logic [TotW-1:0]       tot_q;
  logic [CntW-1:0]       cnt_q, rcv_q, rcv_d;
  logic [MAX_CHUNKS-1:0] seen_q, seen_d;
  logic                  rdy_q, rdy_d;

  logic            newer, adopt, hdr_ok, ceil_ok, stored;
  logic [31:0]     prod, prod_lo, off, expect_len, eff_tot_ext;
  logic [TotW-1:0] eff_tot;
  logic [CntW-1:0] eff_cnt, eff_rcv;
  logic [16:0]     idx_ext, eff_cnt_ext;
  logic [IdxW-1:0] idx;
  logic            eff_seen, last;
  crt_pkg::status_e status;

  // header check, ceil(total / chunk) worked out by bounds on count * chunk
  assign prod    = {16'b0, hdr_i.n_chunks} * {16'b0, ChunkC};
  assign prod_lo = prod - {16'b0, ChunkC};
  assign ceil_ok = (prod >= hdr_i.xfer_size) &&
                   ((hdr_i.n_chunks == '0) ? (hdr_i.xfer_size == '0)
                                           : (prod_lo < hdr_i.xfer_size));
  assign hdr_ok  = ({16'b0, hdr_i.name_len} < NameMaxC) &&
                   (hdr_i.xfer_size < MaxBytesC) &&
                   ({1'b0, hdr_i.n_chunks} <= MaxChC) && ceil_ok;

  assign newer = hdr_i.generation > cur_gen_q;

  // a newer generation with a sound header that is not the generation that failed last
  assign adopt = newer && hdr_ok && (hdr_i.generation != rej_gen_q);

  // geometry as seen after a possible adoption
  assign eff_tot     = adopt ? hdr_i.xfer_size[TotW-1:0] : tot_q;
  assign eff_cnt     = adopt ? hdr_i.n_chunks[CntW-1:0] : cnt_q;
  assign eff_rcv     = adopt ? '0 : rcv_q;
  assign eff_tot_ext = 32'(eff_tot);
  assign eff_cnt_ext = 17'(eff_cnt);
  assign idx_ext     = {1'b0, hdr_i.chunk_no};
  assign idx         = hdr_i.chunk_no[IdxW-1:0];
  assign eff_seen    = adopt ? 1'b0 : seen_q[idx];

  // offset and expected length of this chunk
  assign off        = {16'b0, hdr_i.chunk_no} * {16'b0, ChunkC};
  assign last       = idx_ext == (eff_cnt_ext - 17'd1);
  assign expect_len = !last ? {16'b0, ChunkC} :
                      (eff_tot_ext >= off) ? (eff_tot_ext - off) : '0;

  // status decision in check order
  always_comb begin
    status = crt_pkg::StStored;
    if (hdr_i.generation == rej_gen_q) begin
      status = crt_pkg::StFailed;
    end else if (hdr_i.generation < cur_gen_q) begin
      status = crt_pkg::StStale;
    end else if (newer && !hdr_ok) begin
      status = crt_pkg::StHeader;
    end else begin
      if (hdr_i.xfer_size != eff_tot_ext || {1'b0, hdr_i.n_chunks} != eff_cnt_ext) begin
        status = crt_pkg::StGeometry;
      end else if (idx_ext >= eff_cnt_ext || idx_ext >= MaxChC) begin
        status = crt_pkg::StIndex;
      end else if ({16'b0, hdr_i.payload_len} != expect_len) begin
        status = crt_pkg::StLength;
      end
    end
  end

  assign stored = status == crt_pkg::StStored;

  // bitmap, counter and ready after this chunk
  always_comb begin
    seen_d = adopt ? '0 : seen_q;
    if (stored) begin
      seen_d[idx] = 1'b1;
    end
  end
  assign rcv_d = eff_rcv + CntW'(stored && !eff_seen);
  assign rdy_d = (!adopt && rdy_q) || (stored && rcv_d == eff_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_gen_q <= '0;
      rej_gen_q <= '0;
      tot_q     <= '0;
      cnt_q     <= '0;
      seen_q    <= '0;
      rcv_q     <= '0;
      rdy_q     <= 1'b0;
    end else if (fire_i) begin
      if (status == crt_pkg::StHeader) begin
        rej_gen_q <= hdr_i.generation;
      end
      if (adopt) begin
        cur_gen_q <= hdr_i.generation;
        tot_q     <= eff_tot;
        cnt_q     <= eff_cnt;
      end
      seen_q <= seen_d;
      rcv_q  <= rcv_d;
      rdy_q  <= rdy_d;
    end
  end

  // result beat
  assign res_o.status       = status;
  assign res_o.adopted      = adopt;
  assign res_o.write_offset = stored ? off[crt_pkg::OffsetW-1:0] : '0;
  assign res_o.write_len    = stored ? hdr_i.payload_len[crt_pkg::WlenW-1:0] : '0;
  assign res_o.ready_res    = rdy_d;

  // counter never runs past the chunk count
  assert property (@(posedge clk_i) disable iff (!rst_ni) rcv_q <= cnt_q)
    else $error("received counter above chunk count");

  // counter tracks the bitmap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   32'(rcv_q) == 32'($countones(seen_q)))
    else $error("received counter out of step with bitmap");

  // ready only with every chunk of a non-empty transfer present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   rdy_q |-> (rcv_q == cnt_q) && (cnt_q != '0))
    else $error("ready without a complete transfer");

  // a chunk that is neither adopted nor stored leaves the tracking alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   fire_i && !adopt && !stored |=> $stable(rcv_q) && $stable(rdy_q))
    else $error("rejected chunk changed tracking state");

endmodule

FILE: hw/rtl/chunk_reassembly_tracker.sv
// Chunk reassembly tracker: takes one chunk header per beat and returns one
// result beat per header, at a rate of one chunk per clock while m_axis_tready
// is high; input register, then check logic into the result register. The
// header check, geometry check and bitmap update all sit in the single stage
// between those two registers, and a received counter stands in for a scan
// of the bitmap, so every chunk sees the state left by the one before.
// Chunks of the failed generation or of an older one are dropped; a newer
// generation is adopted when its header is sound, which clears the bitmap,
// counter and ready flag at once, and is marked failed otherwise. Stored
// chunks report the write offset and length for an external payload copier.
module chunk_reassembly_tracker #(
  parameter int CHUNK_SIZE  = 1024,
  parameter int MAX_CHUNKS  = 256,
  parameter int MAX_BYTES   = 262144,
  parameter int NAME_MAX    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // generation[31:0], xfer_size[63:32], n_chunks[79:64],
  // chunk_no[95:80], payload_len[111:96], name_len[127:112]
  input  logic [crt_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[2:0], adopted[3], write_offset[21:4], write_len[32:22],
  // ready_res[33], zero[39:34]
  output logic [crt_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic          hdr_valid, core_ready;
  logic [crt_pkg::InDataW-1:0] hdr_bits;
  logic [crt_pkg::ResW-1:0]    res_bits;
  crt_pkg::hdr_t hdr;
  crt_pkg::res_t res;

  // input register
  crt_stage #(.W(crt_pkg::InDataW)) u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (hdr_valid),
    .out_ready_i (core_ready),
    .out_data_o  (hdr_bits)
  );

  assign hdr = crt_pkg::hdr_t'(hdr_bits);

  // check logic and tracking state
  crt_core #(
    .CHUNK_SIZE  (CHUNK_SIZE),
    .MAX_CHUNKS  (MAX_CHUNKS),
    .MAX_BYTES   (MAX_BYTES),
    .NAME_MAX    (NAME_MAX)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (hdr_valid && core_ready),
    .hdr_i  (hdr),
    .res_o  (res)
  );

  // result register
  crt_stage #(.W(crt_pkg::ResW)) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hdr_valid),
    .in_ready_o  (core_ready),
    .in_data_i   (crt_pkg::ResW'(res)),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_bits)
  );

  assign m_axis_tdata = crt_pkg::OutDataW'(res_bits);

endmodule
